/* hw/rtl/gsm_pkg.sv */
// Group status monitor: shared types, opcodes, register indexes and constants.
// Used by every module of the block; no dependencies.
package gsm_pkg;

	// Table holds entries 1..GROUP_SIZE; the device field is 4 bits, so at most 15.
	localparam int GROUP_SIZE = 15;
	localparam int DEV_W      = 4;

	localparam logic [DEV_W-1:0] OWN_RESET = DEV_W'(1);
	localparam logic [15:0]      TLIM_RESET = 16'h0000;
	localparam logic [15:0]      FLIM_RESET = 16'hFFFF;

	// PDOP 6.0 in tenths
	localparam logic [9:0] PDOP_LIMIT = 10'd60;

	// flag byte layout
	localparam int BATT_MSB  = 2;
	localparam int FIX_BIT   = 3;
	localparam int PDOP_BIT  = 4;
	localparam int ALARM_BIT = 5;

	typedef enum logic [2:0] {
		OP_RX    = 3'd0,
		OP_OWN   = 3'd1,
		OP_FIELD = 3'd2,
		OP_DIST  = 3'd3,
		OP_MEM   = 3'd4,
		OP_EVAL  = 3'd5,
		OP_QUERY = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		FLD_BATT  = 2'd0,
		FLD_FIX   = 2'd1,
		FLD_PDOP  = 2'd2,
		FLD_ALARM = 2'd3
	} field_t;

	typedef enum logic [1:0] {
		REG_OWN  = 2'd0,
		REG_TLIM = 2'd1,
		REG_FLIM = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DEV_W-1:0] own;
		logic [15:0]      tlim;
		logic [15:0]      flim;
	} cfg_t;

	// one command beat traveling down the cell chain, with its result so far
	typedef struct packed {
		logic             valid;
		opcode_t          op;
		logic [DEV_W-1:0] dev;
		logic [31:0]      uptime;
		logic [7:0]       fbyte;
		field_t           sel;
		logic [2:0]       val;
		logic [31:0]      meters;
		logic [9:0]       pdop;
		logic             fix;
		logic             present;
		logic [7:0]       flag;
		logic             tmark;
		logic             fmark;
		logic [31:0]      elapsed;
		logic             aa;
		logic             at;
		logic             af;
	} beat_t;

endpackage

/* hw/rtl/gsm_regs.sv */
// Group status monitor: APB configuration registers.
// Depends on gsm_pkg.
module gsm_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output gsm_pkg::cfg_t     cfg,
	output logic              own_wr
);
	import gsm_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign own_wr = wr_en && (idx == REG_OWN);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own  <= OWN_RESET;
			cfg_q.tlim <= TLIM_RESET;
			cfg_q.flim <= FLIM_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_OWN:  cfg_q.own  <= pwdata[DEV_W-1:0];
				REG_TLIM: cfg_q.tlim <= pwdata[15:0];
				REG_FLIM: cfg_q.flim <= pwdata[15:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OWN:  prdata = 32'(cfg_q.own);
			REG_TLIM: prdata = 32'(cfg_q.tlim);
			REG_FLIM: prdata = 32'(cfg_q.flim);
			default:  prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/gsm_cell.sv */
// Group status monitor: one table entry and its stage of the command chain.
// Depends on gsm_pkg.
module gsm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [gsm_pkg::DEV_W-1:0] idx,
	input  gsm_pkg::cfg_t             cfg,
	input  logic                      own_wr,
	input  gsm_pkg::beat_t            beat_in,
	output gsm_pkg::beat_t            beat_out
);
	import gsm_pkg::*;

	logic        present_q, mem_q, tmark_q, fmark_q;
	logic [31:0] seen_q, dist_q, elapsed_q;
	logic [7:0]  flag_q;

	logic        present_n, mem_n, tmark_n, fmark_n;
	logic [31:0] seen_n, dist_n, elapsed_n;
	logic [7:0]  flag_n;

	logic        is_own, own_hit, dev_hit, present_cur;
	beat_t       beat_n, beat_q;

	assign is_own      = (idx == cfg.own);
	assign own_hit     = beat_in.valid && is_own;
	assign dev_hit     = beat_in.valid && (idx == beat_in.dev);
	assign present_cur = present_q || is_own;

	always_comb begin
		present_n = present_q;
		mem_n     = mem_q;
		tmark_n   = tmark_q;
		fmark_n   = fmark_q;
		seen_n    = seen_q;
		dist_n    = dist_q;
		elapsed_n = elapsed_q;
		flag_n    = flag_q;
		beat_n    = beat_in;

		// own entry keeps its mark when the own number moves away
		if (own_wr && is_own) begin
			present_n = 1'b1;
		end

		case (beat_in.op)
			OP_RX: begin
				if (dev_hit) begin
					present_n = 1'b1;
					seen_n    = beat_in.uptime;
					flag_n    = beat_in.fbyte;
				end
			end
			OP_OWN: begin
				if (own_hit) begin
					seen_n           = beat_in.uptime;
					flag_n[FIX_BIT]  = beat_in.fix;
					flag_n[PDOP_BIT] = (beat_in.pdop <= PDOP_LIMIT);
				end
			end
			OP_FIELD: begin
				if (own_hit) begin
					unique case (beat_in.sel)
						FLD_BATT:  flag_n[BATT_MSB:0] = beat_in.val;
						FLD_FIX:   flag_n[FIX_BIT]    = beat_in.val[0];
						FLD_PDOP:  flag_n[PDOP_BIT]   = beat_in.val[0];
						FLD_ALARM: flag_n[ALARM_BIT]  = beat_in.val[0];
					endcase
				end
			end
			OP_DIST: begin
				if (dev_hit) begin
					dist_n = beat_in.meters;
				end
			end
			OP_MEM: begin
				if (dev_hit) begin
					mem_n = beat_in.val[0];
				end
			end
			OP_EVAL: begin
				if (beat_in.valid) begin
					if (present_cur) begin
						elapsed_n = beat_in.uptime - seen_q;
					end
					if (!mem_q && (cfg.tlim != '0)) begin
						tmark_n   = (elapsed_n > 32'(cfg.tlim));
						beat_n.at = beat_in.at | tmark_n;
					end
					if (present_cur) begin
						fmark_n   = (dist_q > 32'(cfg.flim));
						beat_n.af = beat_in.af | fmark_n;
					end
					beat_n.aa = beat_in.aa | flag_q[ALARM_BIT];
				end
			end
			default: ;
		endcase

		if (dev_hit) begin
			beat_n.present = present_n || is_own;
			beat_n.flag    = flag_n;
			beat_n.tmark   = tmark_n;
			beat_n.fmark   = fmark_n;
			beat_n.elapsed = elapsed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			mem_q     <= 1'b0;
			tmark_q   <= 1'b0;
			fmark_q   <= 1'b0;
			seen_q    <= '0;
			dist_q    <= '0;
			elapsed_q <= '0;
			flag_q    <= '0;
		end else begin
			present_q <= present_n;
			mem_q     <= mem_n;
			tmark_q   <= tmark_n;
			fmark_q   <= fmark_n;
			seen_q    <= seen_n;
			dist_q    <= dist_n;
			elapsed_q <= elapsed_n;
			flag_q    <= flag_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else begin
			beat_q <= beat_n;
		end
	end

	assign beat_out = beat_q;

endmodule

/* hw/rtl/group_status_monitor_core.sv */
// Group status monitor top level: APB registers and the chain of entry cells.
// Depends on gsm_pkg, gsm_regs, gsm_cell.
//
// Each command beat walks the row of GROUP_SIZE entry cells, one cell per clock,
// and its result leaves the last cell on done once it has passed every cell's
// beat register. busy stays high while the beat is in any cell but the last, so
// a new command can be taken at the earliest in the cycle its predecessor's
// result shows. The result is shown for one cycle only and cannot be held off:
// sample it when done is high. Write registers only while no command is in flight.
module group_status_monitor_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                opcode,
	input  logic [gsm_pkg::DEV_W-1:0] device,
	input  logic [31:0]               uptime,
	input  logic [7:0]                flags_byte,
	input  logic [1:0]                field_select,
	input  logic [2:0]                field_value,
	input  logic [31:0]               distance,
	input  logic [9:0]                pdop_tenths,
	input  logic                      fix_3d,
	output logic                      done,
	output logic [gsm_pkg::DEV_W-1:0] entry_device,
	output logic                      entry_present,
	output logic [2:0]                battery_level,
	output logic                      fix_is_3d,
	output logic                      pdop_good,
	output logic                      alarm_raised,
	output logic                      timed_out,
	output logic                      outside_fence,
	output logic [31:0]               elapsed_time,
	output logic                      any_alarm,
	output logic                      any_timeout,
	output logic                      any_fence
);
	import gsm_pkg::*;

	cfg_t                  cfg;
	logic                  own_wr;
	beat_t                 chain [0:GROUP_SIZE];
	logic [GROUP_SIZE-1:0] vld;
	beat_t                 res;

	gsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.own_wr  (own_wr)
	);

	always_comb begin
		chain[0]         = '0;
		chain[0].valid   = start && !busy;
		chain[0].op      = opcode_t'(opcode);
		chain[0].dev     = device;
		chain[0].uptime  = uptime;
		chain[0].fbyte   = flags_byte;
		chain[0].sel     = field_t'(field_select);
		chain[0].val     = field_value;
		chain[0].meters  = distance;
		chain[0].pdop    = pdop_tenths;
		chain[0].fix     = fix_3d;
	end

	for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
		gsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (DEV_W'(i + 1)),
			.cfg      (cfg),
			.own_wr   (own_wr),
			.beat_in  (chain[i]),
			.beat_out (chain[i+1])
		);
		assign vld[i] = chain[i+1].valid;
	end

	// last cell holds the result beat; it does not block intake
	assign busy = |vld[GROUP_SIZE-2:0];
	assign res  = chain[GROUP_SIZE];

	assign done          = res.valid;
	assign entry_device  = res.dev;
	assign entry_present = res.present;
	assign battery_level = res.flag[BATT_MSB:0];
	assign fix_is_3d     = res.flag[FIX_BIT];
	assign pdop_good     = res.flag[PDOP_BIT];
	assign alarm_raised  = res.flag[ALARM_BIT];
	assign timed_out     = res.tmark;
	assign outside_fence = res.fmark;
	assign elapsed_time  = res.elapsed;
	assign any_alarm     = res.aa;
	assign any_timeout   = res.at;
	assign any_fence     = res.af;

endmodule

/* hw/rtl/gsm_checker.sv */
// Group status monitor: port-level checker and its bind to the top level.
// Depends on gsm_pkg and group_status_monitor_core.
module gsm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [gsm_pkg::DEV_W-1:0] entry_device,
	input logic                      entry_present,
	input logic [31:0]               elapsed_time,
	input logic                      timed_out
);
	import gsm_pkg::*;

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##GROUP_SIZE done)
		else $error("result beat missing after accepted command");

	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, GROUP_SIZE))
		else $error("result beat without accepted command");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted command");

	a_bad_dev: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (entry_device == '0)) |->
		(!entry_present && !timed_out && (elapsed_time == '0)))
		else $error("invalid device reported entry data");

endmodule

bind group_status_monitor_core gsm_checker u_gsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.entry_device  (entry_device),
	.entry_present (entry_present),
	.elapsed_time  (elapsed_time),
	.timed_out     (timed_out)
);

/* verif/group_status_monitor_checker.sv */
// Checker for group_status_monitor_core. It watches the APB write port and the
// command and result channels, keeps its own copy of the status table and compares
// every result beat field by field. Depends on gsm_pkg.
`timescale 1ns / 100ps

module group_status_monitor_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	input  logic                      start,
	input  logic                      busy,
	input  logic [2:0]                opcode,
	input  logic [gsm_pkg::DEV_W-1:0] device,
	input  logic [31:0]               uptime,
	input  logic [7:0]                flags_byte,
	input  logic [1:0]                field_select,
	input  logic [2:0]                field_value,
	input  logic [31:0]               distance,
	input  logic [9:0]                pdop_tenths,
	input  logic                      fix_3d,
	input  logic                      done,
	input  logic [gsm_pkg::DEV_W-1:0] entry_device,
	input  logic                      entry_present,
	input  logic [2:0]                battery_level,
	input  logic                      fix_is_3d,
	input  logic                      pdop_good,
	input  logic                      alarm_raised,
	input  logic                      timed_out,
	input  logic                      outside_fence,
	input  logic [31:0]               elapsed_time,
	input  logic                      any_alarm,
	input  logic                      any_timeout,
	input  logic                      any_fence,
	output int                        fail_count,
	output int                        pending_count
);
	import gsm_pkg::*;

	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic             present;
		logic [2:0]       battery;
		logic             fix;
		logic             pdop;
		logic             alarm;
		logic             tmo;
		logic             fence;
		logic [31:0]      elapsed;
		logic             aa;
		logic             at;
		logic             af;
	} entry_report_t;

	entry_report_t expected_reports[$];

	logic [DEV_W-1:0] own_num;
	logic [15:0]      timeout_lim;
	logic [15:0]      fence_lim;

	logic        present_tbl [0:GROUP_SIZE];
	logic        memory_tbl  [0:GROUP_SIZE];
	logic [31:0] seen_tbl    [0:GROUP_SIZE];
	logic [7:0]  flag_tbl    [0:GROUP_SIZE];
	logic [31:0] dist_tbl    [0:GROUP_SIZE];
	logic [31:0] age_tbl     [0:GROUP_SIZE];
	logic        timeout_tbl [0:GROUP_SIZE];
	logic        fence_tbl   [0:GROUP_SIZE];

	function automatic logic slot_valid(logic [DEV_W-1:0] idx);
		return (idx != '0) && (int'(idx) <= GROUP_SIZE);
	endfunction

	task automatic clear_table();
		own_num     = OWN_RESET;
		timeout_lim = TLIM_RESET;
		fence_lim   = FLIM_RESET;
		for (int i = 0; i <= GROUP_SIZE; i++) begin
			present_tbl[i] = 1'b0;
			memory_tbl[i]  = 1'b0;
			seen_tbl[i]    = '0;
			flag_tbl[i]    = '0;
			dist_tbl[i]    = '0;
			age_tbl[i]     = '0;
			timeout_tbl[i] = 1'b0;
			fence_tbl[i]   = 1'b0;
		end
		present_tbl[OWN_RESET] = 1'b1;
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_OWN: begin
				own_num = value[DEV_W-1:0];
				if (slot_valid(own_num))
					present_tbl[own_num] = 1'b1;
			end
			REG_TLIM: timeout_lim = value[15:0];
			REG_FLIM: fence_lim = value[15:0];
			default: ;
		endcase
	endtask

	// applies one command beat to the table and returns the report it produces
	function automatic entry_report_t run_command(
		logic [2:0] op, logic [DEV_W-1:0] dev, logic [31:0] now, logic [7:0] fb,
		logic [1:0] sel, logic [2:0] val, logic [31:0] meters, logic [9:0] pdop,
		logic fix);
		entry_report_t r;
		logic dev_ok;
		logic own_ok;
		r = '0;
		dev_ok = slot_valid(dev);
		own_ok = slot_valid(own_num);
		case (op)
			OP_RX: if (dev_ok) begin
				present_tbl[dev] = 1'b1;
				seen_tbl[dev]    = now;
				flag_tbl[dev]    = fb;
			end
			OP_OWN: if (own_ok) begin
				seen_tbl[own_num]           = now;
				flag_tbl[own_num][FIX_BIT]  = fix;
				flag_tbl[own_num][PDOP_BIT] = (pdop <= PDOP_LIMIT);
			end
			OP_FIELD: if (own_ok) begin
				case (sel)
					FLD_BATT:  flag_tbl[own_num][BATT_MSB:0] = val;
					FLD_FIX:   flag_tbl[own_num][FIX_BIT]    = val[0];
					FLD_PDOP:  flag_tbl[own_num][PDOP_BIT]   = val[0];
					default:   flag_tbl[own_num][ALARM_BIT]  = val[0];
				endcase
			end
			OP_DIST: if (dev_ok)
				dist_tbl[dev] = meters;
			OP_MEM: if (dev_ok)
				memory_tbl[dev] = val[0];
			OP_EVAL: begin
				for (int i = 1; i <= GROUP_SIZE; i++) begin
					if (present_tbl[i])
						age_tbl[i] = now - seen_tbl[i];
					if (!memory_tbl[i] && timeout_lim != '0) begin
						timeout_tbl[i] = age_tbl[i] > {16'h0, timeout_lim};
						if (timeout_tbl[i])
							r.at = 1'b1;
					end
					if (present_tbl[i]) begin
						fence_tbl[i] = dist_tbl[i] > {16'h0, fence_lim};
						if (fence_tbl[i])
							r.af = 1'b1;
					end
					if (flag_tbl[i][ALARM_BIT])
						r.aa = 1'b1;
				end
			end
			default: ;
		endcase
		r.dev = dev;
		if (dev_ok) begin
			r.present = present_tbl[dev];
			r.battery = flag_tbl[dev][BATT_MSB:0];
			r.fix     = flag_tbl[dev][FIX_BIT];
			r.pdop    = flag_tbl[dev][PDOP_BIT];
			r.alarm   = flag_tbl[dev][ALARM_BIT];
			r.tmo     = timeout_tbl[dev];
			r.fence   = fence_tbl[dev];
			r.elapsed = age_tbl[dev];
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		entry_report_t want;
		if (!arst_n) begin
			clear_table();
			expected_reports.delete();
		end else begin
			if (done) begin
				if (expected_reports.size() == 0) begin
					$error("result beat for device %0h with nothing pending", entry_device);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("entry_device", 32'(want.dev), 32'(entry_device));
					check_field("entry_present", 32'(want.present), 32'(entry_present));
					check_field("battery_level", 32'(want.battery), 32'(battery_level));
					check_field("fix_is_3d", 32'(want.fix), 32'(fix_is_3d));
					check_field("pdop_good", 32'(want.pdop), 32'(pdop_good));
					check_field("alarm_raised", 32'(want.alarm), 32'(alarm_raised));
					check_field("timed_out", 32'(want.tmo), 32'(timed_out));
					check_field("outside_fence", 32'(want.fence), 32'(outside_fence));
					check_field("elapsed_time", want.elapsed, elapsed_time);
					check_field("any_alarm", 32'(want.aa), 32'(any_alarm));
					check_field("any_timeout", 32'(want.at), 32'(any_timeout));
					check_field("any_fence", 32'(want.af), 32'(any_fence));
				end
			end
			if (psel && penable && pwrite && pready)
				write_register(paddr[3:2], pwdata);
			if (start && !busy)
				expected_reports.push_back(run_command(opcode, device, uptime, flags_byte,
					field_select, field_value, distance, pdop_tenths, fix_3d));
		end
		pending_count = expected_reports.size();
	end

endmodule

/* verif/group_status_monitor_core_tb.sv */
// Testbench top for group_status_monitor_core: clock, reset, APB register writes
// and command stimulus, plus the verdict. Depends on gsm_pkg, the block and
// group_status_monitor_checker, which predicts and compares the results.
`timescale 1ns / 100ps

module group_status_monitor_core_tb;
	import gsm_pkg::*;

	localparam logic [2:0] OP_UNUSED   = 3'd7;
	localparam int         QUIET_LIMIT = 1000;
	localparam int         PHASES      = 8;
	localparam int         PHASE_BEATS = 116;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [3:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;
	logic             start;
	logic             busy;
	logic [2:0]       opcode;
	logic [DEV_W-1:0] device;
	logic [31:0]      uptime;
	logic [7:0]       flags_byte;
	logic [1:0]       field_select;
	logic [2:0]       field_value;
	logic [31:0]      distance;
	logic [9:0]       pdop_tenths;
	logic             fix_3d;
	logic             done;
	logic [DEV_W-1:0] entry_device;
	logic             entry_present;
	logic [2:0]       battery_level;
	logic             fix_is_3d;
	logic             pdop_good;
	logic             alarm_raised;
	logic             timed_out;
	logic             outside_fence;
	logic [31:0]      elapsed_time;
	logic             any_alarm;
	logic             any_timeout;
	logic             any_fence;

	int          fail_count;
	int          pending_count;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	logic [31:0] clock_base;
	logic [15:0] fence_setting;

	group_status_monitor_core uut (.*);

	group_status_monitor_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("group_status_monitor_core regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// drops start and waits until every pending result beat has come back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic send_command(int gap, logic [2:0] op, logic [DEV_W-1:0] dev,
		logic [31:0] now, logic [7:0] fb, logic [1:0] sel, logic [2:0] val,
		logic [31:0] meters, logic [9:0] pdop, logic fix);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode       <= op;
		device       <= dev;
		uptime       <= now;
		flags_byte   <= fb;
		field_select <= sel;
		field_value  <= val;
		distance     <= meters;
		pdop_tenths  <= pdop;
		fix_3d       <= fix;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_random();
		int          gap;
		int          pick;
		int          dpick;
		logic [2:0]  op;
		logic [31:0] now;
		logic [31:0] meters;
		logic [9:0]  pdop;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 14) == 0) begin
			burst_left = $urandom_range(10, 30);
			gap = 0;
		end else
			gap = $urandom_range(0, 18);
		pick = $urandom_range(0, 99);
		if (pick < 22)      op = OP_RX;
		else if (pick < 32) op = OP_OWN;
		else if (pick < 42) op = OP_FIELD;
		else if (pick < 57) op = OP_DIST;
		else if (pick < 65) op = OP_MEM;
		else if (pick < 80) op = OP_EVAL;
		else if (pick < 96) op = OP_QUERY;
		else                op = OP_UNUSED;
		clock_base += $urandom_range(0, 400);
		now = ($urandom_range(0, 9) == 0) ? $urandom() : clock_base;
		dpick = $urandom_range(0, 9);
		if (dpick < 6)
			meters = $urandom_range(0, 2 * int'(fence_setting) + 1);
		else if (dpick < 8)
			meters = {16'h0, fence_setting} + $urandom_range(0, 1);
		else
			meters = $urandom();
		pdop = ($urandom_range(0, 4) == 0) ? 10'(PDOP_LIMIT + $urandom_range(0, 1))
			: 10'($urandom_range(0, 1023));
		send_command(gap, op, ($urandom_range(0, 19) == 0) ? '0 : DEV_W'($urandom_range(1, 15)),
			now, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
			3'($urandom_range(0, 7)), meters, pdop, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [DEV_W-1:0] own;
		logic [15:0]      tlim;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		start        <= 1'b0;
		opcode       <= '0;
		device       <= '0;
		uptime       <= '0;
		flags_byte   <= '0;
		field_select <= '0;
		field_value  <= '0;
		distance     <= '0;
		pdop_tenths  <= '0;
		fix_3d       <= 1'b0;
		fence_setting = FLIM_RESET;
		clock_base    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, own entry present from reset
		send_command(0, OP_QUERY, 4'd1, '0, '0, '0, '0, '0, '0, 1'b0);
		send_command(2, OP_QUERY, 4'd0, '0, '0, '0, '0, '0, '0, 1'b0);
		send_command(0, OP_UNUSED, 4'd5, '1, '1, '1, '1, '1, '1, 1'b1);
		send_command(0, OP_RX, 4'd3, 32'hFFFF_FFFF, 8'hFF, '0, '0, '0, '0, 1'b0);
		send_command(1, OP_RX, 4'd15, 32'h0, 8'h00, '0, '0, '0, '0, 1'b0);
		send_command(0, OP_RX, 4'd0, 32'h55, 8'hFF, '0, '0, '0, '0, 1'b0);
		send_command(0, OP_OWN, 4'd1, 32'd100, '0, '0, '0, '0, 10'd60, 1'b1);
		send_command(3, OP_OWN, 4'd1, 32'd200, '0, '0, '0, '0, 10'd61, 1'b0);
		send_command(0, OP_OWN, 4'd1, 32'd250, '0, '0, '0, '0, 10'd1023, 1'b1);
		send_command(0, OP_OWN, 4'd1, 32'd300, '0, '0, '0, '0, 10'd0, 1'b0);
		send_command(0, OP_FIELD, 4'd1, '0, '0, FLD_BATT, 3'd7, '0, '0, 1'b0);
		send_command(0, OP_FIELD, 4'd1, '0, '0, FLD_FIX, 3'd3, '0, '0, 1'b0);
		send_command(0, OP_FIELD, 4'd1, '0, '0, FLD_PDOP, 3'd6, '0, '0, 1'b0);
		send_command(0, OP_FIELD, 4'd1, '0, '0, FLD_ALARM, 3'd7, '0, '0, 1'b0);
		send_command(0, OP_RX, 4'd1, 32'd400, 8'hA5, '0, '0, '0, '0, 1'b0);
		send_command(0, OP_DIST, 4'd3, '0, '0, '0, '0, 32'hFFFF_FFFF, '0, 1'b0);
		send_command(0, OP_DIST, 4'd15, '0, '0, '0, '0, 32'h0, '0, 1'b0);
		send_command(0, OP_MEM, 4'd15, '0, '0, '0, 3'd1, '0, '0, 1'b0);
		send_command(0, OP_MEM, 4'd0, '0, '0, '0, 3'd7, '0, '0, 1'b0);
		send_command(0, OP_EVAL, 4'd3, 32'd5, '0, '0, '0, '0, '0, 1'b0);
		drain();
		repeat (GROUP_SIZE + 2) @(negedge clk);
		write_reg(REG_TLIM, 32'd1);
		write_reg(REG_FLIM, 32'd0);
		send_command(0, OP_EVAL, 4'd3, 32'd0, '0, '0, '0, '0, '0, 1'b0);
		send_command(0, OP_QUERY, 4'd15, '0, '0, '0, '0, '0, '0, 1'b0);
		drain();
		repeat (GROUP_SIZE + 2) @(negedge clk);
		// no valid own entry: own updates are dropped
		write_reg(REG_OWN, 32'd0);
		send_command(0, OP_OWN, 4'd1, 32'd900, '0, '0, '0, '0, 10'd5, 1'b1);
		send_command(0, OP_FIELD, 4'd1, '0, '0, FLD_ALARM, 3'd0, '0, '0, 1'b0);
		send_command(0, OP_QUERY, 4'd1, '0, '0, '0, '0, '0, '0, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			own = (phase == 0) ? 4'd15 : (phase == 1) ? 4'd0 : (phase == 2) ? 4'd1
				: DEV_W'($urandom_range(1, 15));
			if (phase == 0)      tlim = 16'hFFFF;
			else if (phase == 1) tlim = 16'd1;
			else if (phase == 3) tlim = 16'd0;
			else if (phase < 6)  tlim = 16'($urandom_range(2, 2000));
			else                 tlim = 16'($urandom_range(0, 65535));
			fence_setting = (phase == 0) ? 16'h0 : (phase == 2) ? 16'hFFFF
				: 16'($urandom_range(0, 65535));
			clock_base = (phase == 4) ? 32'hFFFF_F000 : $urandom();
			drain();
			repeat (GROUP_SIZE + 2) @(negedge clk);
			write_reg(REG_OWN, {28'h0, own});
			write_reg(REG_TLIM, {16'h0, tlim});
			write_reg(REG_FLIM, {16'h0, fence_setting});
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if ($urandom_range(0, 49) == 0)
					drain();
				send_random();
			end
		end

		drain();
		repeat (GROUP_SIZE + 5) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("group_status_monitor_core regression: pass");
		else
			$display("group_status_monitor_core regression: fail");
		$finish;
	end

endmodule
